FILE: hdl/bbpf_pkg.sv
// Shared widths, stream layout and defaults for the Brownian bridge path fill.
// No dependencies; used by brownian_bridge_path_fill and bbpf_sum_sat.
package bbpf_pkg;

    localparam int DEFAULT_MAX_STEPS = 1024;

    // item field widths
    localparam int SLOT_W   = 11;
    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 17;
    localparam int SPREAD_W = 31;

    // path tag kept beside each stored value; tag 0 is never a live path
    localparam int EPOCH_W = 16;

    // datapath widths
    localparam int PROD_W      = VALUE_W + WEIGHT_W + 1 - 1; // signed value x unsigned weight
    localparam int SPROD_W     = SPREAD_W + VALUE_W;          // unsigned spread x signed sample
    localparam int ACC_W       = 64;
    localparam int ALIGN_SHIFT = 8;                           // Q.40 -> Q.48
    localparam int ROUND_SHIFT = 24;                          // Q.48 -> Q.24

    // stream words
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 48;

endpackage

FILE: hdl/brownian_bridge_path_fill.sv
// Brownian bridge path fill: an accepted word passes the registered stages to
// m_tvalid, one word per cycle unless held by a pending or running clear pass,
// an output stall or a word in flight yet to write its left or right slot.
// Reset (aresetn low, synchronous) empties the pipeline and starts a clear pass
// over all MAX_STEPS path store entries, rerun after a drain every 2^16-2 paths.
// Depends on bbpf_pkg and bbpf_sum_sat.
module brownian_bridge_path_fill #(
    parameter int MAX_STEPS = bbpf_pkg::DEFAULT_MAX_STEPS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_slot, right_slot, mid_slot, left_weight, right_weight, spread,
    // normal_sample, zero fill
    input  logic [bbpf_pkg::S_TDATA_W-1:0]   s_tdata,
    // first_of_path
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_slot, path_value, zero fill
    output logic [bbpf_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int SlotW = bbpf_pkg::SLOT_W;
    localparam int ValW  = bbpf_pkg::VALUE_W;
    localparam int WgtW  = bbpf_pkg::WEIGHT_W;
    localparam int SprW  = bbpf_pkg::SPREAD_W;
    localparam int EpW   = bbpf_pkg::EPOCH_W;
    localparam int ProdW = bbpf_pkg::PROD_W;
    localparam int SProdW = bbpf_pkg::SPROD_W;
    localparam int AW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [AW-1:0] ClrLast = AW'(MAX_STEPS - 1);
    localparam logic [EpW-1:0] EpochFirst = EpW'(1);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_CLEAR = 1'b1;

    typedef struct packed {
        logic [EpW-1:0]         tag;
        logic signed [ValW-1:0] val;
    } entry_t;

    function automatic logic slot_ok(input logic [SlotW-1:0] slot);
        return (slot != '0) && (32'(slot) <= MAX_STEPS);
    endfunction

    // input word fields
    logic                   in_first;
    logic [SlotW-1:0]       in_lslot;
    logic [SlotW-1:0]       in_rslot;
    logic [SlotW-1:0]       in_mslot;
    logic [WgtW-1:0]        in_wl;
    logic [WgtW-1:0]        in_wr;
    logic [SprW-1:0]        in_sd;
    logic signed [ValW-1:0] in_z;

    assign in_first = s_tuser[0];
    assign in_lslot = s_tdata[10:0];
    assign in_rslot = s_tdata[21:11];
    assign in_mslot = s_tdata[32:22];
    assign in_wl    = s_tdata[49:33];
    assign in_wr    = s_tdata[66:50];
    assign in_sd    = s_tdata[97:67];
    assign in_z     = $signed(s_tdata[129:98]);

    // control
    logic           state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [EpW-1:0] epoch_reg, epoch_next;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic           en1, en2, en3, en4;
    logic           s_fire;
    logic           wrap_req;
    logic           hazard;
    logic           pipe_empty;
    logic           wr_pipe;
    logic [EpW-1:0] in_epoch;
    logic           in_l_ok, in_r_ok;
    logic           fwd_l, fwd_r;

    // stage 1: read data and operands
    entry_t                 rd_l_reg, rd_r_reg;
    entry_t                 s1_fwd_reg;
    logic                   s1_fwd_l_reg, s1_fwd_r_reg;
    logic                   s1_l_ok_reg, s1_r_ok_reg;
    logic [SlotW-1:0]       s1_mid_reg;
    logic                   s1_mid_ok_reg;
    logic [EpW-1:0]         s1_epoch_reg;
    logic [WgtW-1:0]        s1_wl_reg, s1_wr_reg;
    logic [SprW-1:0]        s1_sd_reg;
    logic signed [ValW-1:0] s1_z_reg;
    entry_t                 s1_l_ent, s1_r_ent;
    logic signed [ValW-1:0] s1_lv, s1_rv;

    // stage 2: multiplies
    logic signed [ValW-1:0] s2_lv_reg, s2_rv_reg;
    logic [WgtW-1:0]        s2_wl_reg, s2_wr_reg;
    logic [SprW-1:0]        s2_sd_reg;
    logic signed [ValW-1:0] s2_z_reg;
    logic [SlotW-1:0]       s2_mid_reg;
    logic                   s2_mid_ok_reg;
    logic [EpW-1:0]         s2_epoch_reg;

    // stage 3: sum, round, saturate
    logic signed [ProdW-1:0]  s3_pl_reg, s3_pr_reg;
    logic signed [SProdW-1:0] s3_ps_reg;
    logic [SlotW-1:0]         s3_mid_reg;
    logic                     s3_mid_ok_reg;
    logic [EpW-1:0]           s3_epoch_reg;
    logic signed [ValW-1:0]   s3_q;

    // output word
    logic [SlotW-1:0]       out_slot_reg;
    logic signed [ValW-1:0] out_val_reg;

    // path store
    entry_t         mem_array [0:MAX_STEPS-1];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    entry_t         mem_wdata;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign wr_pipe    = v3_reg && en4 && s3_mid_ok_reg;

    assign in_l_ok = slot_ok(in_lslot);
    assign in_r_ok = slot_ok(in_rslot);

    // an older word still ahead of its store write; the stage 3 word that
    // writes at this edge is forwarded instead
    always_comb begin
        hazard = 1'b0;
        if (!in_first) begin
            hazard = (in_l_ok && ((v1_reg && s1_mid_ok_reg && s1_mid_reg == in_lslot)
                              || (v2_reg && s2_mid_ok_reg && s2_mid_reg == in_lslot)
                              || (v3_reg && !en4 && s3_mid_ok_reg && s3_mid_reg == in_lslot)))
                  || (in_r_ok && ((v1_reg && s1_mid_ok_reg && s1_mid_reg == in_rslot)
                              || (v2_reg && s2_mid_ok_reg && s2_mid_reg == in_rslot)
                              || (v3_reg && !en4 && s3_mid_ok_reg && s3_mid_reg == in_rslot)));
        end
    end

    assign fwd_l = wr_pipe && (s3_mid_reg == in_lslot);
    assign fwd_r = wr_pipe && (s3_mid_reg == in_rslot);

    assign wrap_req = s_tvalid && in_first && (&epoch_reg);
    assign s_tready = en1 && (state_reg == ST_RUN) && !hazard && !wrap_req;
    assign s_fire   = s_tvalid && s_tready;
    assign in_epoch = in_first ? epoch_reg + EpW'(1) : epoch_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        epoch_next   = epoch_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_fire) begin
                    epoch_next = in_epoch;
                end
                if (wrap_req && pipe_empty) begin
                    state_next   = ST_CLEAR;
                    clr_cnt_next = '0;
                end
            end
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == ClrLast) begin
                    state_next   = ST_RUN;
                    clr_cnt_next = '0;
                    epoch_next   = EpochFirst;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            epoch_reg   <= EpochFirst;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            epoch_reg   <= epoch_next;
        end
    end

    // path store: clear pass writes tag 0, which no live path uses
    always_comb begin
        mem_we    = (state_reg == ST_CLEAR) || wr_pipe;
        mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : AW'(s3_mid_reg - SlotW'(1));
        mem_wdata.tag = (state_reg == ST_CLEAR) ? '0 : s3_epoch_reg;
        mem_wdata.val = (state_reg == ST_CLEAR) ? '0 : s3_q;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            rd_l_reg <= mem_array[AW'(in_lslot - SlotW'(1))];
            rd_r_reg <= mem_array[AW'(in_rslot - SlotW'(1))];
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_fire;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1 load
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_fwd_reg.tag <= s3_epoch_reg;
            s1_fwd_reg.val <= s3_q;
            s1_fwd_l_reg   <= fwd_l;
            s1_fwd_r_reg   <= fwd_r;
            s1_l_ok_reg    <= in_l_ok;
            s1_r_ok_reg    <= in_r_ok;
            s1_mid_reg     <= in_mslot;
            s1_mid_ok_reg  <= slot_ok(in_mslot);
            s1_epoch_reg   <= in_epoch;
            s1_wl_reg      <= in_wl;
            s1_wr_reg      <= in_wr;
            s1_sd_reg      <= in_sd;
            s1_z_reg       <= in_z;
        end
    end

    // unwritten slots (stale tag) read as zero
    always_comb begin
        s1_l_ent = s1_fwd_l_reg ? s1_fwd_reg : rd_l_reg;
        s1_r_ent = s1_fwd_r_reg ? s1_fwd_reg : rd_r_reg;
        s1_lv = (s1_l_ok_reg && s1_l_ent.tag == s1_epoch_reg) ? s1_l_ent.val : '0;
        s1_rv = (s1_r_ok_reg && s1_r_ent.tag == s1_epoch_reg) ? s1_r_ent.val : '0;
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            s2_lv_reg     <= s1_lv;
            s2_rv_reg     <= s1_rv;
            s2_wl_reg     <= s1_wl_reg;
            s2_wr_reg     <= s1_wr_reg;
            s2_sd_reg     <= s1_sd_reg;
            s2_z_reg      <= s1_z_reg;
            s2_mid_reg    <= s1_mid_reg;
            s2_mid_ok_reg <= s1_mid_ok_reg;
            s2_epoch_reg  <= s1_epoch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            s3_pl_reg     <= s2_lv_reg * $signed({1'b0, s2_wl_reg});
            s3_pr_reg     <= s2_rv_reg * $signed({1'b0, s2_wr_reg});
            s3_ps_reg     <= $signed({1'b0, s2_sd_reg}) * s2_z_reg;
            s3_mid_reg    <= s2_mid_reg;
            s3_mid_ok_reg <= s2_mid_ok_reg;
            s3_epoch_reg  <= s2_epoch_reg;
        end
    end

    bbpf_sum_sat u_sum_sat (
        .left_prod  (s3_pl_reg),
        .right_prod (s3_pr_reg),
        .noise_prod (s3_ps_reg),
        .value      (s3_q)
    );

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            out_slot_reg <= s3_mid_reg;
            out_val_reg  <= s3_q;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(bbpf_pkg::M_TDATA_W - SlotW - ValW){1'b0}}, out_val_reg, out_slot_reg};

`ifndef SYNTHESIS
    // no word enters while the store is being swept
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_fire)
        else $error("input word accepted during clear pass");

    // sweep only starts with nothing in flight that would still write
    a_clear_on_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && state_next == ST_CLEAR) |-> pipe_empty)
        else $error("clear pass started with words in flight");

    // a sweep always restarts the path tag at EpochFirst
    a_epoch_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR ##1 state_reg == ST_RUN) |-> (epoch_reg == EpochFirst))
        else $error("path tag not restarted after clear pass");

    // output word only appears from a filled stage 3
    a_out_from_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v3_reg))
        else $error("output valid without a stage 3 word");
`endif

endmodule

FILE: hdl/bbpf_sum_sat.sv
// Adds the two weighted neighbor terms and the noise term, rounds to Q8.24
// and saturates to the signed 32-bit range. Depends on bbpf_pkg.
module bbpf_sum_sat (
    input  logic signed [bbpf_pkg::PROD_W-1:0]  left_prod,
    input  logic signed [bbpf_pkg::PROD_W-1:0]  right_prod,
    input  logic signed [bbpf_pkg::SPROD_W-1:0] noise_prod,
    output logic signed [bbpf_pkg::VALUE_W-1:0] value
);

    localparam int AccW   = bbpf_pkg::ACC_W;
    localparam int ValW   = bbpf_pkg::VALUE_W;
    localparam int Align  = bbpf_pkg::ALIGN_SHIFT;
    localparam int RShift = bbpf_pkg::ROUND_SHIFT;

    localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
    localparam logic signed [AccW-1:0] Half   = AccW'(1) <<< (RShift - 1);

    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] shifted;
    logic                   ovf_hi;
    logic                   ovf_lo;

    always_comb begin
        acc = (AccW'(left_prod) <<< Align) + (AccW'(right_prod) <<< Align)
            + AccW'(noise_prod) + Half;
        // round half up: bias then floor shift
        shifted = acc >>> RShift;
        ovf_hi  = !shifted[AccW-1] && (|shifted[AccW-2:ValW-1]);
        ovf_lo  = shifted[AccW-1] && !(&shifted[AccW-2:ValW-1]);
        priority if (ovf_hi) begin
            value = ValMax;
        end else if (ovf_lo) begin
            value = ValMin;
        end else begin
            value = $signed(shifted[ValW-1:0]);
        end
    end

endmodule

FILE: sim/brownian_bridge_path_fill_tb.sv
// Self-checking bench for brownian_bridge_path_fill: a directed table of bridge nodes, then
// random paths with stray nodes and noise words, checked against table values or a local path predictor.
// Depends on bbpf_pkg and the brownian_bridge_path_fill RTL.
`timescale 1ns / 1ps

module brownian_bridge_path_fill_tb;

    localparam int SLOT_W       = bbpf_pkg::SLOT_W;
    localparam int VALUE_W      = bbpf_pkg::VALUE_W;
    localparam int WEIGHT_W     = bbpf_pkg::WEIGHT_W;
    localparam int SPREAD_W     = bbpf_pkg::SPREAD_W;
    localparam int ROUND_SHIFT  = bbpf_pkg::ROUND_SHIFT;
    localparam int S_TDATA_W    = bbpf_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = bbpf_pkg::M_TDATA_W;
    localparam int S_PAD_W      = S_TDATA_W - 3 * SLOT_W - 2 * WEIGHT_W - SPREAD_W - VALUE_W;
    localparam int MAX_STEPS    = bbpf_pkg::DEFAULT_MAX_STEPS;
    localparam int RANDOM_WORDS = 1180;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        bit                           first;
        logic [SLOT_W-1:0]            left_slot;
        logic [SLOT_W-1:0]            right_slot;
        logic [SLOT_W-1:0]            mid_slot;
        logic [WEIGHT_W-1:0]          left_weight;
        logic [WEIGHT_W-1:0]          right_weight;
        logic [SPREAD_W-1:0]          spread;
        logic signed [VALUE_W-1:0]    sample;
    } node_t;

    typedef struct {
        node_t              node;
        bit                 fixed;
        logic [VALUE_W-1:0] value;
    } node_row_t;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } path_point_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    brownian_bridge_path_fill #(
        .MAX_STEPS (MAX_STEPS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state: one path at a time
    logic signed [VALUE_W-1:0] path_val  [1:MAX_STEPS];
    bit                        slot_live [1:MAX_STEPS];

    path_point_t pending_points[$];
    node_row_t   node_table[$];

    bit          calm = 1'b1;
    int          err_count   = 0;
    int          words_sent  = 0;
    int          random_sent = 0;
    int          paths_seen  = 0;
    int          sat_count   = 0;
    int          pause_count = 0;
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_points.size());
            $display("[brownian_bridge_path_fill] ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [VALUE_W-1:0] predict_node(input node_t n);
        longint lv;
        longint rv;
        longint acc;
        longint q;
        if (n.first) begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            paths_seen++;
        end
        lv = 0;
        rv = 0;
        if (n.left_slot != 0 && n.left_slot <= MAX_STEPS && slot_live[n.left_slot])
            lv = longint'(path_val[n.left_slot]);
        if (n.right_slot != 0 && n.right_slot <= MAX_STEPS && slot_live[n.right_slot])
            rv = longint'(path_val[n.right_slot]);
        // weighted terms are Q.40, lifted to Q.48 to line up with spread * sample
        acc = (lv * longint'(n.left_weight)) * 256 + (rv * longint'(n.right_weight)) * 256
            + longint'(n.spread) * longint'(n.sample);
        q = (acc + 64'sd8388608) >>> ROUND_SHIFT;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            sat_count++;
        end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            sat_count++;
        end
        if (n.mid_slot != 0 && n.mid_slot <= MAX_STEPS) begin
            path_val[n.mid_slot]  = q[VALUE_W-1:0];
            slot_live[n.mid_slot] = 1'b1;
        end
        return q[VALUE_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
        $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
        err_count++;
    endtask

    function automatic void add_row(input bit f, input int unsigned ls, input int unsigned rs,
                                    input int unsigned ms, input int unsigned lw,
                                    input int unsigned rw, input int unsigned sd, input int z,
                                    input bit fixed, input logic [VALUE_W-1:0] value);
        node_row_t row;
        row.node.first        = f;
        row.node.left_slot    = SLOT_W'(ls);
        row.node.right_slot   = SLOT_W'(rs);
        row.node.mid_slot     = SLOT_W'(ms);
        row.node.left_weight  = WEIGHT_W'(lw);
        row.node.right_weight = WEIGHT_W'(rw);
        row.node.spread       = SPREAD_W'(sd);
        row.node.sample       = z;
        row.fixed             = fixed;
        row.value             = value;
        node_table.insert(node_table.size(), row);
    endfunction

    task automatic send_node(input node_t n, input bit fixed, input logic [VALUE_W-1:0] fixed_val);
        int gap;
        logic [VALUE_W-1:0] want;
        path_point_t pt;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= n.first;
        s_tdata  <= {{S_PAD_W{1'b0}}, n.sample, n.spread, n.right_weight, n.left_weight,
                     n.mid_slot, n.right_slot, n.left_slot};
        do @(posedge aclk); while (!s_tready);
        want = predict_node(n);
        if (fixed)
            want = fixed_val;
        pt.slot  = n.mid_slot;
        pt.value = want;
        pending_points.insert(pending_points.size(), pt);
        words_sent++;
    endtask

    // hold the input side off until every outstanding word has come back
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_points.size() != 0);
        pause_count++;
    endtask

    task automatic send_random(input node_t n);
        if (random_sent % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
        if (random_sent % 300 == 150)
            drain_pause();
        send_node(n, 1'b0, '0);
        random_sent++;
    endtask

    function automatic logic [SLOT_W-1:0] pick_parent(ref logic [SLOT_W-1:0] live[$]);
        int r;
        int span;
        r = $urandom_range(0, 99);
        if (live.size() == 0 || r < 15)
            return '0;
        // recent parents stress forwarding from words still in flight
        if (r < 60) begin
            span = (live.size() > 3) ? 3 : live.size();
            return live[live.size() - 1 - $urandom_range(0, span - 1)];
        end
        if (r < 95)
            return live[$urandom_range(0, live.size() - 1)];
        return SLOT_W'($urandom_range(1, MAX_STEPS));
    endfunction

    function automatic void draw_values(inout node_t n);
        n.left_weight  = ($urandom_range(0, 9) == 0) ? WEIGHT_W'($urandom_range(0, 131071))
                                                      : WEIGHT_W'($urandom_range(0, 65536));
        n.right_weight = ($urandom_range(0, 9) == 0) ? WEIGHT_W'($urandom_range(0, 131071))
                                                      : WEIGHT_W'($urandom_range(0, 65536));
        if ($urandom_range(0, 4) != 0) begin
            n.spread = SPREAD_W'($urandom_range(0, 1 << 25));
            n.sample = int'($urandom_range(0, 8 << 24)) - (4 << 24);
        end else begin
            n.spread = SPREAD_W'($urandom);
            n.sample = $urandom;
        end
    endfunction

    task automatic run_random_paths(input int target);
        node_t n;
        int len;
        logic [SLOT_W-1:0] live[$];
        while (random_sent < target) begin
            if ($urandom_range(0, 99) < 15) begin
                n.first        = 1'($urandom_range(0, 1));
                n.left_slot    = SLOT_W'($urandom);
                n.right_slot   = SLOT_W'($urandom);
                n.mid_slot     = SLOT_W'($urandom);
                n.left_weight  = WEIGHT_W'($urandom);
                n.right_weight = WEIGHT_W'($urandom);
                n.spread       = SPREAD_W'($urandom);
                n.sample       = $urandom;
                send_random(n);
            end else begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(200, MAX_STEPS)
                                                   : $urandom_range(2, 24);
                live.delete();
                for (int k = 0; k < len && random_sent < target; k++) begin
                    n.first      = (k == 0);
                    n.left_slot  = pick_parent(live);
                    n.right_slot = pick_parent(live);
                    n.mid_slot   = SLOT_W'($urandom_range(1, MAX_STEPS));
                    // occasional broken node: stray neighbor or out-of-range midpoint
                    if ($urandom_range(0, 19) == 0)
                        n.left_slot = SLOT_W'($urandom);
                    if ($urandom_range(0, 29) == 0)
                        n.mid_slot = ($urandom_range(0, 1) == 0) ? '0
                                   : SLOT_W'($urandom_range(1025, 2047));
                    draw_values(n);
                    if (n.mid_slot != 0 && n.mid_slot <= MAX_STEPS)
                        live.insert(live.size(), n.mid_slot);
                    send_random(n);
                end
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        logic [SLOT_W-1:0]  got_slot;
        logic [VALUE_W-1:0] got_val;
        path_point_t        want;
        m_tready = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got_slot = m_tdata[SLOT_W-1:0];
            got_val  = m_tdata[SLOT_W +: VALUE_W];
            if (pending_points.size() == 0) begin
                note_mismatch("unexpected word, slot/value", VALUE_W'(got_slot), got_val);
            end else begin
                want = pending_points.pop_front();
                if (got_slot !== want.slot)
                    note_mismatch("out_slot", VALUE_W'(got_slot), VALUE_W'(want.slot));
                if (got_val !== want.value)
                    note_mismatch("path_value", got_val, want.value);
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        //      first  left  right mid   lw      rw      spread        sample
        add_row(1, 0,    0,    1,    65536,  65536,  0,            32'h7FFF_FFFF, 1, 32'h0);
        // neighbors never written since reset
        add_row(0, 5,    6,    7,    131071, 131071, 32'h7FFF_FFFF, 0,            1, 32'h0);
        add_row(0, 0,    0,    1024, 0,      0,      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF);
        add_row(0, 0,    0,    1023, 0,      0,      32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000);
        add_row(0, 0,    0,    2,    0,      0,      1 << 24,      1 << 24,       1, 32'h0100_0000);
        add_row(0, 2,    1,    3,    65536,  0,      0,            0,             1, 32'h0100_0000);
        add_row(0, 1024, 1023, 4,    131071, 131071, 0,            0,             0, 32'h0);
        add_row(0, 1024, 0,    5,    131071, 0,      0,            0,             1, 32'h7FFF_FFFF);
        add_row(0, 1023, 0,    6,    65536,  0,      0,            0,             1, 32'h8000_0000);
        // zero weight on a written neighbor
        add_row(0, 1024, 0,    8,    0,      0,      0,            0,             1, 32'h0);
        // midpoint zero and beyond the store: emitted, not kept
        add_row(0, 0,    0,    0,    0,      0,      1 << 24,      -(1 << 24),    1, 32'hFF00_0000);
        add_row(0, 0,    0,    2047, 0,      0,      1 << 24,      5 << 24,       1, 32'h0500_0000);
        add_row(0, 2047, 1025, 9,    65536,  65536,  0,            0,             1, 32'h0);
        add_row(0, 0,    1025, 10,   65536,  65536,  0,            0,             1, 32'h0);
        // rounding at half an LSB, both signs
        add_row(0, 0,    0,    11,   0,      0,      1,            1 << 23,       1, 32'h1);
        add_row(0, 0,    0,    12,   0,      0,      1,            -(1 << 23),    1, 32'h0);
        add_row(0, 0,    0,    13,   0,      0,      1,            -(1 << 23) - 1, 1, 32'hFFFF_FFFF);
        // new path drops every stored value
        add_row(1, 1024, 2,    14,   65536,  65536,  0,            0,             1, 32'h0);
        add_row(0, 0,    0,    20,   0,      0,      1 << 24,      3 << 24,       1, 32'h0300_0000);
        // back-to-back parents
        add_row(0, 20,   0,    21,   32768,  0,      1 << 24,      1 << 24,       0, 32'h0);
        add_row(0, 21,   20,   22,   65536,  65536,  0,            0,             0, 32'h0);
        add_row(0, 22,   22,   22,   65536,  65536,  32'h7FFF_FFFF, -1,           0, 32'h0);
        add_row(1, 2047, 2047, 2047, 131071, 131071, 32'h7FFF_FFFF, -1,           0, 32'h0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        calm = 1'b1;
        foreach (node_table[i])
            send_node(node_table[i].node, node_table[i].fixed, node_table[i].value);
        drain_pause();

        run_random_paths(RANDOM_WORDS);

        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("covered %0d words (%0d directed), %0d paths, %0d saturated values",
                 words_sent, node_table.size(), paths_seen, sat_count);
        $display("sender drained the pipeline %0d times; %0d mismatches", pause_count, err_count);
        if (err_count == 0)
            $display("[brownian_bridge_path_fill] OK");
        else
            $display("[brownian_bridge_path_fill] ERROR");
        $finish;
    end

endmodule
